@@ rtl/core/amsup_pkg.sv @@
// Shared types and constants for the actuator move supervisor.
package amsup_pkg;

   localparam int HEIGHT_WIDTH   = 16;
   localparam int SPEED_WIDTH    = 16;
   localparam int ACTION_WIDTH   = 2;
   localparam int COMMAND_WIDTH  = 2;
   localparam int REASON_WIDTH   = 3;
   localparam int INTERVAL_WIDTH = 14;
   localparam int ELAPSED_WIDTH  = 16;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [ACTION_WIDTH-1:0] ACT_START  = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_REPORT = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_TICK   = 2'd2;

   localparam logic [COMMAND_WIDTH-1:0] CMD_NONE   = 2'd0;
   localparam logic [COMMAND_WIDTH-1:0] CMD_START  = 2'd1;
   localparam logic [COMMAND_WIDTH-1:0] CMD_RESEND = 2'd2;
   localparam logic [COMMAND_WIDTH-1:0] CMD_STOP   = 2'd3;

   localparam logic [REASON_WIDTH-1:0] END_NONE        = 3'd0;
   localparam logic [REASON_WIDTH-1:0] END_ARRIVED     = 3'd1;
   localparam logic [REASON_WIDTH-1:0] END_NO_REPORT   = 3'd2;
   localparam logic [REASON_WIDTH-1:0] END_NO_PROGRESS = 3'd3;
   localparam logic [REASON_WIDTH-1:0] END_STALLED     = 3'd4;
   localparam logic [REASON_WIDTH-1:0] END_WRONG_DIR   = 3'd5;

   localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET = 14'd200;
   localparam logic [ELAPSED_WIDTH-1:0]  ELAPSED_MAX    = '1;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0]        action;
      logic [HEIGHT_WIDTH-1:0]        target_height;
      logic [HEIGHT_WIDTH-1:0]        current_height;
      logic                           link_up;
      logic [HEIGHT_WIDTH-1:0]        reported_height;
      logic signed [SPEED_WIDTH-1:0]  reported_speed;
   } item_type;

   typedef struct packed {
      logic                      accepted;
      logic [COMMAND_WIDTH-1:0]  command;
      logic [HEIGHT_WIDTH-1:0]   command_height;
      logic [REASON_WIDTH-1:0]   end_reason;
      logic                      busy_res;
   } result_type;

endpackage

@@ rtl/core/amsup_ifs.sv @@
// Valid/ready channel interfaces for request and response transactions.
interface amsup_req_if;
   import amsup_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [ACTION_WIDTH-1:0]       action;
   logic [HEIGHT_WIDTH-1:0]       target_height;
   logic [HEIGHT_WIDTH-1:0]       current_height;
   logic                          link_up;
   logic [HEIGHT_WIDTH-1:0]       reported_height;
   logic signed [SPEED_WIDTH-1:0] reported_speed;

   modport source (
      output valid, action, target_height, current_height, link_up,
             reported_height, reported_speed,
      input  ready
   );

   modport sink (
      input  valid, action, target_height, current_height, link_up,
             reported_height, reported_speed,
      output ready
   );
endinterface

interface amsup_rsp_if;
   import amsup_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      accepted;
   logic [COMMAND_WIDTH-1:0]  command;
   logic [HEIGHT_WIDTH-1:0]   command_height;
   logic [REASON_WIDTH-1:0]   end_reason;
   logic                      busy_res;

   modport source (
      output valid, accepted, command, command_height, end_reason, busy_res,
      input  ready
   );

   modport sink (
      input  valid, accepted, command, command_height, end_reason, busy_res,
      output ready
   );
endinterface

@@ rtl/core/amsup_csr.sv @@
// APB-style register file holding the resend interval.
module amsup_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [amsup_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [amsup_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [amsup_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                  csr_pready,
   output logic [amsup_pkg::INTERVAL_WIDTH-1:0]  interval
);
   import amsup_pkg::*;

   logic [INTERVAL_WIDTH-1:0] interval_ff;
   logic [INTERVAL_WIDTH-1:0] interval_in;
   logic                      write_en;
   logic                      addr_unused;

   // single register occupies the whole byte range of the port
   assign addr_unused = ^csr_paddr;
   assign csr_pready  = 1'b1;
   assign write_en    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      interval_in = interval_ff;
      if (write_en) begin
         interval_in = csr_pwdata[INTERVAL_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else begin
         interval_ff <= interval_in;
      end
   end

   assign csr_prdata = {{(CSR_DATA_WIDTH-INTERVAL_WIDTH){addr_unused & 1'b0}}, interval_ff};
   assign interval   = interval_ff;

endmodule

@@ rtl/core/amsup_engine.sv @@
// Move supervision state and per-transaction decision logic.
module amsup_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  amsup_pkg::item_type                   item,
   input  logic [amsup_pkg::INTERVAL_WIDTH-1:0]  interval,
   output amsup_pkg::result_type                 result
);
   import amsup_pkg::*;

   logic                      moving_ff,      moving_in;
   logic                      going_up_ff,    going_up_in;
   logic [HEIGHT_WIDTH-1:0]   goal_ff,        goal_in;
   logic [HEIGHT_WIDTH-1:0]   prior_ff,       prior_in;
   logic                      prior_valid_ff, prior_valid_in;
   logic [HEIGHT_WIDTH-1:0]   latest_h_ff,    latest_h_in;
   logic [SPEED_WIDTH-1:0]    latest_s_ff,    latest_s_in;
   logic                      seen_ff,        seen_in;
   logic [ELAPSED_WIDTH-1:0]  elapsed_ff,     elapsed_in;

   logic [ELAPSED_WIDTH-1:0]  elapsed_inc;
   logic                      due;
   logic [REASON_WIDTH-1:0]   reason;
   logic                      rising;

   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign due         = elapsed_inc > {{(ELAPSED_WIDTH-INTERVAL_WIDTH){1'b0}}, interval};
   assign rising      = !latest_s_ff[SPEED_WIDTH-1];

   always_comb begin
      if (!seen_ff) begin
         reason = END_NO_REPORT;
      end else if (prior_valid_ff && (prior_ff == latest_h_ff)) begin
         reason = END_NO_PROGRESS;
      end else if (latest_h_ff == goal_ff) begin
         reason = END_ARRIVED;
      end else if (latest_s_ff == '0) begin
         reason = END_STALLED;
      end else if (rising != going_up_ff) begin
         reason = END_WRONG_DIR;
      end else begin
         reason = END_NONE;
      end
   end

   always_comb begin
      moving_in      = moving_ff;
      going_up_in    = going_up_ff;
      goal_in        = goal_ff;
      prior_in       = prior_ff;
      prior_valid_in = prior_valid_ff;
      latest_h_in    = latest_h_ff;
      latest_s_in    = latest_s_ff;
      seen_in        = seen_ff;
      elapsed_in     = elapsed_ff;
      result         = '0;

      unique case (item.action)
         ACT_START: begin
            if (item.link_up && !moving_ff) begin
               result.accepted = 1'b1;
               if (item.current_height != item.target_height) begin
                  going_up_in           = item.current_height < item.target_height;
                  goal_in               = item.target_height;
                  seen_in               = 1'b0;
                  prior_valid_in        = 1'b0;
                  prior_in              = '0;
                  elapsed_in            = '0;
                  moving_in             = 1'b1;
                  result.command        = CMD_START;
                  result.command_height = item.target_height;
               end
            end
         end
         ACT_REPORT: begin
            latest_h_in = item.reported_height;
            latest_s_in = item.reported_speed;
            seen_in     = 1'b1;
         end
         ACT_TICK: begin
            if (moving_ff) begin
               elapsed_in = elapsed_inc;
               if (due) begin
                  if (reason != END_NONE) begin
                     moving_in         = 1'b0;
                     result.command    = CMD_STOP;
                     result.end_reason = reason;
                  end else begin
                     prior_in              = latest_h_ff;
                     prior_valid_in        = 1'b1;
                     elapsed_in            = '0;
                     result.command        = CMD_RESEND;
                     result.command_height = goal_ff;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      result.busy_res = moving_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ff      <= 1'b0;
         going_up_ff    <= 1'b0;
         goal_ff        <= '0;
         prior_ff       <= '0;
         prior_valid_ff <= 1'b0;
         latest_h_ff    <= '0;
         latest_s_ff    <= '0;
         seen_ff        <= 1'b0;
         elapsed_ff     <= '0;
      end else if (advance) begin
         moving_ff      <= moving_in;
         going_up_ff    <= going_up_in;
         goal_ff        <= goal_in;
         prior_ff       <= prior_in;
         prior_valid_ff <= prior_valid_in;
         latest_h_ff    <= latest_h_in;
         latest_s_ff    <= latest_s_in;
         seen_ff        <= seen_in;
         elapsed_ff     <= elapsed_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      advance && (result.command == CMD_STOP) |=> !moving_ff)
      else $error("move still running after stop");

   assert property (@(posedge clock) disable iff (reset)
      advance |-> ((result.end_reason != END_NONE) == (result.command == CMD_STOP)))
      else $error("end reason and stop command disagree");

   assert property (@(posedge clock) disable iff (reset)
      advance && (result.command == CMD_START) |=>
         moving_ff && (elapsed_ff == '0) && !seen_ff && !prior_valid_ff)
      else $error("start did not restart move records");

   assert property (@(posedge clock) disable iff (reset)
      advance && (result.command == CMD_RESEND) |=>
         moving_ff && prior_valid_ff && (elapsed_ff == '0))
      else $error("resend did not restart progress window");

   assert property (@(posedge clock) disable iff (reset)
      !moving_ff && !advance |=> !moving_ff)
      else $error("move started without a transaction");
`endif

endmodule

@@ rtl/core/actuator_move_supervisor_core.sv @@
// A transaction passes from request acceptance through the input register, then the result register, to response valid.
// Throughput: one transaction per cycle while the response side keeps ready high.
// The decision logic between the two registers is a handful of 16-bit compares.
// Reset: synchronous, clears all move state, empties both stages, interval returns to 200.
// A full result register holds its transaction; the input stage advances when it frees.
module actuator_move_supervisor_core (
   input  logic                                  clock,
   input  logic                                  reset,
   amsup_req_if.sink                             req_if,
   amsup_rsp_if.source                           rsp_if,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [amsup_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [amsup_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [amsup_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                  csr_pready
);
   import amsup_pkg::*;

   logic                      in_valid_ff,  in_valid_in;
   item_type                  in_item_ff,   in_item_in;
   logic                      out_valid_ff, out_valid_in;
   result_type                out_res_ff,   out_res_in;

   logic                      req_fire;
   logic                      rsp_fire;
   logic                      advance;
   result_type                step_res;
   logic [INTERVAL_WIDTH-1:0] interval;

   amsup_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .interval    (interval)
   );

   amsup_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .item     (in_item_ff),
      .interval (interval),
      .result   (step_res)
   );

   assign rsp_fire     = out_valid_ff && rsp_if.ready;
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_fire     = req_if.valid && req_if.ready;

   always_comb begin
      in_item_in.action          = req_if.action;
      in_item_in.target_height   = req_if.target_height;
      in_item_in.current_height  = req_if.current_height;
      in_item_in.link_up         = req_if.link_up;
      in_item_in.reported_height = req_if.reported_height;
      in_item_in.reported_speed  = req_if.reported_speed;

      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_res_in   = step_res;
      end else if (rsp_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= in_item_in;
      end
      out_res_ff <= out_res_in;
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.accepted       = out_res_ff.accepted;
   assign rsp_if.command        = out_res_ff.command;
   assign rsp_if.command_height = out_res_ff.command_height;
   assign rsp_if.end_reason     = out_res_ff.end_reason;
   assign rsp_if.busy_res       = out_res_ff.busy_res;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced transaction not held in result register");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && !advance |=> in_valid_ff)
      else $error("accepted transaction lost from input stage");

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_if.ready |-> !req_if.ready)
      else $error("request taken while both stages are full");
`endif

endmodule

@@ dv/actuator_move_supervisor_core_tb.sv @@
// Self-checking testbench for the actuator move supervisor core.
module actuator_move_supervisor_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import amsup_pkg::*;

   localparam logic [ACTION_WIDTH-1:0]   ACT_UNUSED          = 2'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_RESEND_INTERVAL = 2'd0;
   localparam int                        DRAIN_CYCLES        = 4;
   localparam int                        CYCLE_LIMIT         = 500000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   amsup_req_if req_if ();
   amsup_rsp_if rsp_if ();

   actuator_move_supervisor_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   item_type   pending_items[$];
   result_type expected_outcomes[$];
   int         mismatches   = 0;
   int         items_queued = 0;
   int         cycle_count  = 0;
   bit         no_gaps      = 1'b0;

   // Move supervision state mirrored from the block.
   logic [INTERVAL_WIDTH-1:0] interval_ms   = INTERVAL_RESET;
   logic                      mv_active     = 1'b0;
   logic                      mv_up         = 1'b0;
   logic [HEIGHT_WIDTH-1:0]   mv_goal       = '0;
   logic [HEIGHT_WIDTH-1:0]   checkpoint_h  = '0;
   logic                      checkpoint_ok = 1'b0;
   logic [HEIGHT_WIDTH-1:0]   rep_height    = '0;
   logic [SPEED_WIDTH-1:0]    rep_speed     = '0;
   logic                      rep_seen      = 1'b0;
   logic [ELAPSED_WIDTH-1:0]  ms_count      = '0;

   task automatic supervise(input item_type it, output result_type res);
      logic [REASON_WIDTH-1:0] verdict;
      res = '0;
      case (it.action)
         ACT_START: begin
            if (it.link_up && !mv_active) begin
               res.accepted = 1'b1;
               if (it.current_height != it.target_height) begin
                  mv_up         = it.current_height < it.target_height;
                  mv_goal       = it.target_height;
                  rep_seen      = 1'b0;
                  checkpoint_ok = 1'b0;
                  checkpoint_h  = '0;
                  ms_count      = '0;
                  mv_active     = 1'b1;
                  res.command        = CMD_START;
                  res.command_height = mv_goal;
               end
            end
         end
         ACT_REPORT: begin
            rep_height = it.reported_height;
            rep_speed  = it.reported_speed;
            rep_seen   = 1'b1;
         end
         ACT_TICK: begin
            if (mv_active) begin
               if (ms_count != ELAPSED_MAX) ms_count = ms_count + 1'b1;
               if (ms_count > interval_ms) begin
                  if (!rep_seen) verdict = END_NO_REPORT;
                  else if (checkpoint_ok && checkpoint_h == rep_height) verdict = END_NO_PROGRESS;
                  else if (rep_height == mv_goal) verdict = END_ARRIVED;
                  else if (rep_speed == '0) verdict = END_STALLED;
                  else if (!rep_speed[SPEED_WIDTH-1] != mv_up) verdict = END_WRONG_DIR;
                  else verdict = END_NONE;
                  if (verdict != END_NONE) begin
                     mv_active      = 1'b0;
                     res.command    = CMD_STOP;
                     res.end_reason = verdict;
                  end else begin
                     checkpoint_h       = rep_height;
                     checkpoint_ok      = 1'b1;
                     ms_count           = '0;
                     res.command        = CMD_RESEND;
                     res.command_height = mv_goal;
                  end
               end
            end
         end
         default: ;
      endcase
      res.busy_res = mv_active;
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Request driver: hold the transaction until accepted, idle at random.
   always @(posedge clock) begin : req_drive
      item_type   taken;
      item_type   nxt;
      result_type res;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            taken.action          = req_if.action;
            taken.target_height   = req_if.target_height;
            taken.current_height  = req_if.current_height;
            taken.link_up         = req_if.link_up;
            taken.reported_height = req_if.reported_height;
            taken.reported_speed  = req_if.reported_speed;
            supervise(taken, res);
            expected_outcomes.push_back(res);
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_items.size() != 0 && (no_gaps || $urandom_range(99) >= 32)) begin
               nxt = pending_items.pop_front();
               req_if.valid           <= 1'b1;
               req_if.action          <= nxt.action;
               req_if.target_height   <= nxt.target_height;
               req_if.current_height  <= nxt.current_height;
               req_if.link_up         <= nxt.link_up;
               req_if.reported_height <= nxt.reported_height;
               req_if.reported_speed  <= nxt.reported_speed;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: stall at random, check each transaction in order.
   always @(posedge clock) begin : rsp_monitor
      result_type got;
      result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= no_gaps || ($urandom_range(99) >= 32);
         if (rsp_if.valid && rsp_if.ready) begin
            got.accepted       = rsp_if.accepted;
            got.command        = rsp_if.command;
            got.command_height = rsp_if.command_height;
            got.end_reason     = rsp_if.end_reason;
            got.busy_res       = rsp_if.busy_res;
            if (expected_outcomes.size() == 0) begin
               $display("%0t: response expected none, got %h", $time, got);
               mismatches++;
            end else begin
               want = expected_outcomes.pop_front();
               compare_field("accepted", want.accepted, got.accepted);
               compare_field("command", want.command, got.command);
               compare_field("command_height", want.command_height, got.command_height);
               compare_field("end_reason", want.end_reason, got.end_reason);
               compare_field("busy_res", want.busy_res, got.busy_res);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic item_type random_item();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(item_type)-1:0];
   endfunction

   task automatic push_item(input item_type it);
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic push_start(input logic [15:0] goal, input logic [15:0] from,
                             input logic link);
      item_type it;
      it = random_item();
      it.action         = ACT_START;
      it.target_height  = goal;
      it.current_height = from;
      it.link_up        = link;
      push_item(it);
   endtask

   task automatic push_report(input logic [15:0] height, input logic [15:0] speed);
      item_type it;
      it = random_item();
      it.action          = ACT_REPORT;
      it.reported_height = height;
      it.reported_speed  = speed;
      push_item(it);
   endtask

   task automatic push_ticks(input int count);
      item_type it;
      for (int k = 0; k < count; k++) begin
         it = random_item();
         it.action = ACT_TICK;
         push_item(it);
      end
   endtask

   task automatic push_unused();
      item_type it;
      it = random_item();
      it.action = ACT_UNUSED;
      push_item(it);
   endtask

   task automatic push_noise();
      item_type it;
      it = random_item();
      push_item(it);
   endtask

   // Start a move, then rounds of an optional report and a run of ticks, most runs enough to reach the check.
   task automatic queue_move();
      logic [15:0]        from;
      logic [15:0]        goal;
      logic [15:0]        pos;
      logic signed [15:0] spd;
      logic               up;
      int                 rounds;
      int                 pick;
      int                 mag;
      int                 n;
      from = 16'($urandom);
      goal = 16'($urandom);
      if ($urandom_range(99) < 5) goal = from;
      push_start(goal, from, $urandom_range(99) >= 6);
      up     = from < goal;
      pos    = from;
      rounds = $urandom_range(4, 1);
      for (int k = 0; k < rounds; k++) begin
         if ($urandom_range(99) < 90) begin
            pick = $urandom_range(99);
            if (pick < 55) pos = 16'($urandom_range(pos, goal));
            else if (pick < 70) pos = goal;
            else if (pick >= 80) pos = 16'($urandom);
            mag  = $urandom_range(32767, 1);
            pick = $urandom_range(99);
            if (pick < 65) spd = up ? 16'(mag) : 16'(-mag);
            else if (pick < 80) spd = '0;
            else if (pick < 92) spd = up ? 16'(-mag) : 16'(mag);
            else spd = 16'($urandom);
            push_report(pos, spd);
         end
         if ($urandom_range(99) < 10) push_start(16'($urandom), 16'($urandom), 1'b1);
         pick = $urandom_range(99);
         n    = interval_ms + 1;
         if (pick < 15) n = interval_ms;
         else if (pick < 25) n = n + $urandom_range(3, 1);
         push_ticks(n);
      end
      if ($urandom_range(99) < 50) push_ticks(interval_ms + 1);
   endtask

   task automatic csr_transfer(input logic wr, input logic [31:0] wdata,
                               output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= REG_RESEND_INTERVAL;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_interval_readback();
      logic [31:0] rdata;
      csr_transfer(1'b0, '0, rdata);
      compare_field("resend interval readback", interval_ms, rdata[INTERVAL_WIDTH-1:0]);
   endtask

   task automatic set_interval(input int value);
      logic [31:0] rdata;
      csr_transfer(1'b1, 32'(value), rdata);
      interval_ms = value[INTERVAL_WIDTH-1:0];
      check_interval_readback();
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_if.valid || expected_outcomes.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(input int count, input bit quiet);
      int stop_at;
      no_gaps = quiet;
      stop_at = items_queued + count;
      while (items_queued < stop_at) begin
         if ($urandom_range(99) < 12) push_noise();
         else queue_move();
      end
      drain();
      no_gaps = 1'b0;
   endtask

   initial begin : stimulus
      req_if.valid           = 1'b0;
      req_if.action          = ACT_START;
      req_if.target_height   = '0;
      req_if.current_height  = '0;
      req_if.link_up         = 1'b0;
      req_if.reported_height = '0;
      req_if.reported_speed  = '0;
      rsp_if.ready           = 1'b0;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      check_interval_readback();
      set_interval(0);

      push_ticks(1);
      push_unused();
      push_report(16'hFFFF, 16'h8000);
      push_start(16'hFFFF, 16'h0000, 1'b0);
      push_start(16'hFFFF, 16'hFFFF, 1'b1);
      push_start(16'hFFFF, 16'h0000, 1'b1);
      push_start(16'h0000, 16'hFFFF, 1'b1);
      push_unused();
      push_ticks(1);
      push_start(16'hFFFF, 16'h0000, 1'b1);
      push_report(16'd100, 16'h7FFF);
      push_ticks(1);
      push_report(16'd100, 16'd5);
      push_ticks(1);
      push_start(16'd1000, 16'd0, 1'b1);
      push_report(16'd1000, 16'd1);
      push_ticks(1);
      push_start(16'd1000, 16'd0, 1'b1);
      push_report(16'd500, 16'd0);
      push_ticks(1);
      push_start(16'd0, 16'hFFFF, 1'b1);
      push_report(16'd500, 16'd1);
      push_ticks(1);
      push_start(16'hFFFF, 16'd0, 1'b1);
      push_report(16'd0, 16'hFFFF);
      push_ticks(1);
      drain();

      random_phase(130, 1'b0);
      set_interval(1);
      random_phase(130, 1'b0);
      set_interval(3);
      random_phase(130, 1'b0);
      set_interval(2);
      random_phase(130, 1'b1);
      set_interval($urandom_range(6, 1));
      random_phase(130, 1'b0);

      // A long interval: ticks only count; a short interval then fires the check.
      set_interval(10000);
      push_start(16'd60000, 16'd100, 1'b1);
      push_report(16'd30000, 16'd500);
      push_ticks(40);
      drain();
      set_interval(2);
      push_ticks(1);
      push_report(16'd60000, 16'd500);
      push_ticks(3);
      drain();

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
